// File: design/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg - settings frame parser shared types and constants
// Item and result records, status and error codes, setting ids and the
// reset values of the held settings.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int LenW   = 24;
  localparam int ShiftW = 40;
  localparam int PosW   = 3;

  // result status codes
  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // error kinds
  localparam logic [2:0] EK_NONE       = 3'd0;
  localparam logic [2:0] EK_ACK_BODY   = 3'd1;
  localparam logic [2:0] EK_LENGTH     = 3'd2;
  localparam logic [2:0] EK_PUSH       = 3'd3;
  localparam logic [2:0] EK_WINDOW     = 3'd4;
  localparam logic [2:0] EK_FRAME_SIZE = 3'd5;
  localparam logic [2:0] EK_UNKNOWN    = 3'd6;

  // input item kinds
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BYTE   = 1'b1;

  // setting ids
  localparam logic [15:0] ID_TABLE_SIZE  = 16'd1;
  localparam logic [15:0] ID_PUSH        = 16'd2;
  localparam logic [15:0] ID_STREAMS     = 16'd3;
  localparam logic [15:0] ID_WINDOW      = 16'd4;
  localparam logic [15:0] ID_FRAME_SIZE  = 16'd5;
  localparam logic [15:0] ID_HEADER_LIST = 16'd6;

  localparam logic [PosW-1:0] LAST_ENTRY_POS = 3'd5;

  // reset values of the held settings
  localparam logic [31:0] RST_TABLE_SIZE  = 32'd4096;
  localparam logic        RST_PUSH        = 1'b1;
  localparam logic [31:0] RST_STREAMS     = 32'hFFFF_FFFF;
  localparam logic [30:0] RST_WINDOW      = 31'd65535;
  localparam logic [23:0] RST_FRAME_SIZE  = 24'd16384;
  localparam logic [31:0] RST_HEADER_LIST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]      body_byte;
    logic            ack_flag;
    logic [LenW-1:0] frame_length;
    logic            op;
  } sfp_item_t;

  typedef struct packed {
    logic [31:0] header_list;
    logic [23:0] frame_size;
    logic [30:0] window;
    logic [31:0] streams;
    logic        push;
    logic [31:0] table_size;
  } sfp_settings_t;

  typedef struct packed {
    sfp_settings_t settings;
    logic [2:0]    error_kind;
    logic [1:0]    status;
  } sfp_result_t;

  // Length is a multiple of six when it is even and its residue mod 3 is
  // zero. 16 == 1 (mod 3), so nibble sums keep the residue.
  function automatic logic len_mult_of_six(input logic [LenW-1:0] len);
    logic [6:0] s1;
    logic [4:0] s2;
    logic [3:0] s3;
    logic       m3;
    s1 = 7'(len[3:0]) + 7'(len[7:4]) + 7'(len[11:8])
       + 7'(len[15:12]) + 7'(len[19:16]) + 7'(len[23:20]);
    s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
    s3 = 4'(5'(s2[4]) + 5'(s2[3:0]));
    m3 = (s3 == 4'd0) || (s3 == 4'd3) || (s3 == 4'd6) || (s3 == 4'd9)
      || (s3 == 4'd12) || (s3 == 4'd15);
    return m3 && !len[0];
  endfunction

endpackage

// File: design/sfp_in_stage.sv
// ----------------------------------------------------------------------------
// sfp_in_stage - input register
// Captures one item per transaction and holds it until the parse stage
// moves it on.
// ----------------------------------------------------------------------------
module sfp_in_stage
  import sfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfp_item_t in_item,
  input  logic      advance,
  output logic      fire,
  output sfp_item_t item
);

  logic      valid_r, valid_nxt;
  sfp_item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign fire      = valid_r && advance;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !advance);
  assign item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: design/sfp_engine.sv
// ----------------------------------------------------------------------------
// sfp_engine - settings frame parse state
// Frame header checks, 6-byte entry assembly, entry validation and the
// six held settings. Produces the result of the current item.
// ----------------------------------------------------------------------------
module sfp_engine
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  sfp_item_t   item,
  output sfp_result_t result
);

  logic              in_frame_r, in_frame_nxt;
  logic [LenW-1:0]   bytes_left_r, bytes_left_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [ShiftW-1:0] shift_r, shift_nxt;
  sfp_settings_t     set_r, set_nxt;

  logic [1:0]  status;
  logic [2:0]  err;
  logic [15:0] id;
  logic [31:0] val;
  logic [LenW-1:0] left_dec;

  assign id       = shift_r[39:24];
  assign val      = {shift_r[23:0], item.body_byte};
  assign left_dec = bytes_left_r - 1'b1;

  always_comb begin
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    pos_nxt        = pos_r;
    shift_nxt      = shift_r;
    set_nxt        = set_r;
    status         = ST_BUSY;
    err            = EK_NONE;

    if (item.op == OP_HEADER) begin
      in_frame_nxt   = 1'b0;
      bytes_left_nxt = '0;
      pos_nxt        = '0;
      shift_nxt      = '0;
      priority if (item.ack_flag && (item.frame_length != '0)) begin
        status = ST_ERROR;
        err    = EK_ACK_BODY;
      end else if (!len_mult_of_six(item.frame_length)) begin
        status = ST_ERROR;
        err    = EK_LENGTH;
      end else if (item.frame_length == '0) begin
        status = ST_DONE;
      end else begin
        in_frame_nxt   = 1'b1;
        bytes_left_nxt = item.frame_length;
      end
    end else if (!in_frame_r) begin
      status = ST_IGNORED;
    end else begin
      bytes_left_nxt = left_dec;
      if (pos_r == LAST_ENTRY_POS) begin
        pos_nxt   = '0;
        shift_nxt = '0;
        unique case (id)
          ID_TABLE_SIZE:  set_nxt.table_size = val;
          ID_PUSH: begin
            if (|val[31:1]) err = EK_PUSH;
            else set_nxt.push = val[0];
          end
          ID_STREAMS:     set_nxt.streams = val;
          ID_WINDOW: begin
            if (val[31]) err = EK_WINDOW;
            else set_nxt.window = val[30:0];
          end
          ID_FRAME_SIZE: begin
            // allowed range is 2^14 .. 2^24-1
            if ((|val[31:24]) || !(|val[23:14])) err = EK_FRAME_SIZE;
            else set_nxt.frame_size = val[23:0];
          end
          ID_HEADER_LIST: set_nxt.header_list = val;
          default:        err = EK_UNKNOWN;
        endcase
        priority if (err != EK_NONE) begin
          status         = ST_ERROR;
          in_frame_nxt   = 1'b0;
          bytes_left_nxt = '0;
        end else if (left_dec == '0) begin
          status       = ST_DONE;
          in_frame_nxt = 1'b0;
        end else begin
          status = ST_BUSY;
        end
      end else begin
        pos_nxt   = pos_r + 1'b1;
        shift_nxt = {shift_r[ShiftW-9:0], item.body_byte};
      end
    end
  end

  assign result.status     = status;
  assign result.error_kind = err;
  assign result.settings   = set_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r           <= 1'b0;
      bytes_left_r         <= '0;
      pos_r                <= '0;
      shift_r              <= '0;
      set_r.table_size     <= RST_TABLE_SIZE;
      set_r.push           <= RST_PUSH;
      set_r.streams        <= RST_STREAMS;
      set_r.window         <= RST_WINDOW;
      set_r.frame_size     <= RST_FRAME_SIZE;
      set_r.header_list    <= RST_HEADER_LIST;
    end else if (fire) begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
      pos_r        <= pos_nxt;
      shift_r      <= shift_nxt;
      set_r        <= set_nxt;
    end
  end

endmodule

// File: design/sfp_out_stage.sv
// ----------------------------------------------------------------------------
// sfp_out_stage - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module sfp_out_stage
  import sfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  sfp_result_t result,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_ready,
  output sfp_result_t out_result
);

  logic        valid_r, valid_nxt;
  sfp_result_t result_r;

  assign advance    = !valid_r || out_ready;
  assign valid_nxt  = fire || (valid_r && !out_ready);
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end

endmodule

// File: design/settings_frame_parser.sv
// Each item passes the input register, then the result register behind out_tvalid.
// Throughput: one item per cycle; the input register, the parse logic and
// the result register form a two-register pipeline stalled by out_tready.
// Reset (synchronous, rst_n low): both stages empty, no frame open, held
// settings return to their protocol defaults.
// ----------------------------------------------------------------------------
// settings_frame_parser - settings frame parser top level
// Streams frame headers and body bytes in, one result out per item.
// ----------------------------------------------------------------------------
module settings_frame_parser
  import sfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // frame_length[23:0], ack_flag[24], body_byte[32:25]
  input  logic         in_tuser,   // op[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // error_kind[2:0], header_table_size[34:3], enable_push[35],
  // max_concurrent_streams[67:36], initial_window[98:68],
  // max_frame_size[122:99], max_header_list[154:123]
  output logic [159:0] out_tdata,
  output logic [1:0]   out_tuser   // status[1:0]
);

  sfp_item_t   in_item, item;
  sfp_result_t result, out_result;
  logic        fire, advance;

  assign in_item.op           = in_tuser;
  assign in_item.frame_length = in_tdata[23:0];
  assign in_item.ack_flag     = in_tdata[24];
  assign in_item.body_byte    = in_tdata[32:25];

  sfp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .advance  (advance),
    .fire     (fire),
    .item     (item)
  );

  sfp_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  sfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tuser = out_result.status;
  assign out_tdata = {5'd0,
                      out_result.settings.header_list,
                      out_result.settings.frame_size,
                      out_result.settings.window,
                      out_result.settings.streams,
                      out_result.settings.push,
                      out_result.settings.table_size,
                      out_result.error_kind};

endmodule

// File: design/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker - port-level checks for the settings frame parser
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module sfp_checker
  import sfp_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [159:0] out_tdata,
  input logic [1:0]   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an error kind shows up exactly with the error status
  a_err_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tuser == ST_ERROR) == (out_tdata[2:0] != EK_NONE)))
    else $error("error kind and status disagree");

  // max frame size never drops below 2^14
  a_frame_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[122:113] != 10'd0))
    else $error("max frame size out of range");

  // with no result waiting, an offered transaction is always taken
  a_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !out_tvalid |-> in_tready)
    else $error("input refused while result side empty");

  // no result appears in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind settings_frame_parser sfp_checker u_sfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
